// ===== hw/rtl/nat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nat_pkg
// Shared types, codes and sizes of the node address table.
// ----------------------------------------------------------------------------
package nat_pkg;

   localparam int NAT_TABLE_DEPTH  = 32;
   localparam int NODE_ADDR_W      = 16;
   localparam int HW_ADDR_BYTES    = 6;
   localparam int HW_ADDR_W        = HW_ADDR_BYTES * 8;
   localparam int IDENT_HALF_W     = 64;
   localparam int SLOT_W           = 5;

   // Request opcodes.
   localparam logic [2:0] OP_FIND  = 3'd0;
   localparam logic [2:0] OP_ADD   = 3'd1;
   localparam logic [2:0] OP_QUERY = 3'd2;
   localparam logic [2:0] OP_READ  = 3'd3;
   localparam logic [2:0] OP_CLEAR = 3'd4;

   // Result status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_MISS  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic [2:0]              opcode;
      logic [NODE_ADDR_W-1:0]  node_addr;
      logic [IDENT_HALF_W-1:0] ident_high;
      logic [IDENT_HALF_W-1:0] ident_low;
      logic                    ident_present;
      logic [HW_ADDR_W-1:0]    hw_addr;
      logic                    hw_addr_present;
      logic [7:0]              entry_index;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]              status;
      logic [SLOT_W-1:0]       slot;
      logic                    out_used;
      logic [NODE_ADDR_W-1:0]  out_node_addr;
      logic [IDENT_HALF_W-1:0] out_ident_high;
      logic [IDENT_HALF_W-1:0] out_ident_low;
      logic [HW_ADDR_W-1:0]    out_hw_addr;
   } rsp_payload_type;

   // One stored table entry; the used mark is kept in flip-flops apart.
   typedef struct packed {
      logic [NODE_ADDR_W-1:0]  node_addr;
      logic [IDENT_HALF_W-1:0] ident_high;
      logic [IDENT_HALF_W-1:0] ident_low;
      logic [HW_ADDR_W-1:0]    hw_addr;
   } entry_type;

endpackage

// ===== hw/rtl/nat_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nat_req_if
// Request channel of the node address table: valid, ready and payload.
// ----------------------------------------------------------------------------
interface nat_req_if import nat_pkg::*; ();

   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

// ===== hw/rtl/nat_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nat_rsp_if
// Response channel of the node address table: valid, ready and payload.
// ----------------------------------------------------------------------------
interface nat_rsp_if import nat_pkg::*; ();

   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

// ===== hw/rtl/nat_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nat_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module nat_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 32
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [DATA_W-1:0]                            wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [DATA_W-1:0]                            rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/node_address_table_core.sv =====
`timescale 1ns / 1ps
// Find, add and identifier query scan the table one entry per cycle through a
// single RAM read port and one shared comparator; an add that writes back then
// passes the write state. Read passes the read state; clear, out-of-range read
// and unknown opcodes go straight to the response state. One request in flight;
// the next is taken once the response is posted, even while it waits. Reset
// empties the table at once (used marks cleared).
// ----------------------------------------------------------------------------
// node_address_table_core
// Associative node table with first-free insertion, identifier query,
// indexed read and clear, built around one RAM and a scan sequencer.
// ----------------------------------------------------------------------------
module node_address_table_core import nat_pkg::*; #(
   parameter int TABLE_DEPTH = NAT_TABLE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   nat_req_if.sink      req_ch,
   nat_rsp_if.source    rsp_ch
);

   localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_WRITE,
      S_READ,
      S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [TABLE_DEPTH-1:0] used_ff, used_in;
   req_payload_type   req_ff, req_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              chk_ff, chk_in;
   logic [IDX_W-1:0]  chk_idx_ff, chk_idx_in;
   logic              hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   entry_type         hit_data_ff, hit_data_in;
   logic              free_found_ff, free_found_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   rsp_payload_type   res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;

   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   entry_type          ram_wr_data;
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;

   entry_type          rd_entry;
   logic               match;
   logic               index_in_range;
   logic [IDX_W-1:0]   read_idx;

   nat_ram #(
      .DATA_W (ENTRY_W),
      .DEPTH  (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_entry = entry_type'(ram_rd_data);

   // Shared comparator: the identifier query compares the identifier,
   // find and add compare the node address.
   assign match = (req_ff.opcode == OP_QUERY) ?
                  ((rd_entry.ident_high == req_ff.ident_high) &&
                   (rd_entry.ident_low == req_ff.ident_low)) :
                  (rd_entry.node_addr == req_ff.node_addr);

   assign index_in_range = ({1'b0, req_ch.data.entry_index} < 9'(TABLE_DEPTH));
   assign read_idx       = req_ff.entry_index[IDX_W-1:0];

   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      req_in        = req_ff;
      cnt_in        = cnt_ff;
      chk_in        = chk_ff;
      chk_idx_in    = chk_idx_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_data_in   = hit_data_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = hit_idx_ff;
      ram_wr_data   = hit_data_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = cnt_ff[IDX_W-1:0];

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               req_in        = req_ch.data;
               cnt_in        = '0;
               chk_in        = 1'b0;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               res_in        = '0;
               res_in.status = ST_MISS;
               unique case (req_ch.data.opcode)
                  OP_FIND, OP_ADD, OP_QUERY: begin
                     state_in = S_SCAN;
                  end
                  OP_READ: begin
                     if (index_in_range) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = req_ch.data.entry_index[IDX_W-1:0];
                        state_in    = S_READ;
                     end else begin
                        res_in.status = ST_RANGE;
                        state_in      = S_DONE;
                     end
                  end
                  OP_CLEAR: begin
                     used_in       = '0;
                     res_in.status = ST_OK;
                     state_in      = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // Issue one read per cycle; its data is compared in the cycle after.
            chk_in     = (cnt_ff < CNT_W'(TABLE_DEPTH));
            chk_idx_in = cnt_ff[IDX_W-1:0];
            if (cnt_ff < CNT_W'(TABLE_DEPTH)) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = cnt_ff[IDX_W-1:0];
               cnt_in      = cnt_ff + CNT_W'(1);
            end
            if (chk_ff) begin
               if (used_ff[chk_idx_ff] && match && !hit_found_ff) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = chk_idx_ff;
                  hit_data_in  = rd_entry;
               end
               if (!used_ff[chk_idx_ff] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = chk_idx_ff;
               end
            end
            if ((cnt_ff == CNT_W'(TABLE_DEPTH)) && !chk_ff) begin
               if (req_ff.opcode == OP_ADD) begin
                  if (hit_found_ff || free_found_ff) begin
                     state_in = S_WRITE;
                  end else begin
                     state_in = S_DONE;
                  end
               end else begin
                  if (hit_found_ff) begin
                     res_in.status = ST_OK;
                     res_in.slot   = SLOT_W'(hit_idx_ff);
                  end
                  state_in = S_DONE;
               end
            end
         end

         S_WRITE: begin
            ram_wr_en     = 1'b1;
            res_in.status = ST_OK;
            if (hit_found_ff) begin
               ram_wr_addr = hit_idx_ff;
               ram_wr_data = hit_data_ff;
               if (req_ff.ident_present) begin
                  ram_wr_data.ident_high = req_ff.ident_high;
                  ram_wr_data.ident_low  = req_ff.ident_low;
               end
               if (req_ff.hw_addr_present) begin
                  ram_wr_data.hw_addr = req_ff.hw_addr;
               end
               res_in.slot = SLOT_W'(hit_idx_ff);
            end else begin
               // A claimed entry starts from zero for the absent fields.
               ram_wr_addr            = free_idx_ff;
               ram_wr_data.node_addr  = req_ff.node_addr;
               ram_wr_data.ident_high = req_ff.ident_present ? req_ff.ident_high : '0;
               ram_wr_data.ident_low  = req_ff.ident_present ? req_ff.ident_low : '0;
               ram_wr_data.hw_addr    = req_ff.hw_addr_present ? req_ff.hw_addr : '0;
               used_in[free_idx_ff]   = 1'b1;
               res_in.slot            = SLOT_W'(free_idx_ff);
            end
            state_in = S_DONE;
         end

         S_READ: begin
            // Entries become unused only through clear or reset; an unused entry
            // always reads as zero, since its fields are not passed to the reply.
            res_in.status   = ST_OK;
            res_in.slot     = SLOT_W'(read_idx);
            res_in.out_used = used_ff[read_idx];
            if (used_ff[read_idx]) begin
               res_in.out_node_addr  = rd_entry.node_addr;
               res_in.out_ident_high = rd_entry.ident_high;
               res_in.out_ident_low  = rd_entry.ident_low;
               res_in.out_hw_addr    = rd_entry.hw_addr;
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         chk_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         chk_ff       <= chk_in;
      end
      req_ff        <= req_in;
      chk_idx_ff    <= chk_idx_in;
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      hit_data_ff   <= hit_data_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      res_ff        <= res_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the node address table. Requests are driven through
// the request channel with random gaps. Every accepted transaction is run on a
// shadow copy of the table, which predicts the reply. Replies are checked
// field by field, in order, against those predictions. The response side
// stalls at random, and once it holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
   import nat_pkg::*;

   localparam int         CYCLE_LIMIT   = 400000;
   localparam int         HOLD_CYCLES   = 300;
   localparam int         DRAIN_CYCLES  = 40;
   localparam int         TOTAL_ITEMS   = 1450;
   localparam int         ADDR_POOL_N   = 40;
   localparam int         IDENT_POOL_N  = 8;
   localparam logic [2:0] OP_SPARE_LO   = 3'd5;
   localparam logic [2:0] OP_SPARE_HI   = 3'd7;

   // Shadow of the table plus the queue of replies still owed by the block.
   class node_table_scoreboard;
      bit              entry_used[NAT_TABLE_DEPTH];
      entry_type       entries[NAT_TABLE_DEPTH];
      rsp_payload_type owed_replies[$];
      int              errors;
      int              mismatches;

      function new();
         wipe_table();
         errors     = 0;
         mismatches = 0;
      endfunction

      function void wipe_table();
         foreach (entries[i]) begin
            entry_used[i] = 1'b0;
            entries[i]    = '0;
         end
      endfunction

      function int lowest_addr_match(logic [NODE_ADDR_W-1:0] addr);
         int hit;
         hit = -1;
         for (int i = 0; i < NAT_TABLE_DEPTH && hit < 0; i++)
            if (entry_used[i] && entries[i].node_addr == addr) hit = i;
         return hit;
      endfunction

      function rsp_payload_type predict_reply(req_payload_type r);
         rsp_payload_type p;
         int              hit;
         p        = '0;
         p.status = ST_MISS;
         hit      = -1;
         case (r.opcode)
            OP_FIND: begin
               hit = lowest_addr_match(r.node_addr);
            end
            OP_ADD: begin
               hit = lowest_addr_match(r.node_addr);
               // No match: claim the lowest free entry and start it from zero.
               for (int i = 0; i < NAT_TABLE_DEPTH && hit < 0; i++) begin
                  if (!entry_used[i]) begin
                     hit                  = i;
                     entry_used[i]        = 1'b1;
                     entries[i]           = '0;
                     entries[i].node_addr = r.node_addr;
                  end
               end
               if (hit >= 0) begin
                  if (r.ident_present) begin
                     entries[hit].ident_high = r.ident_high;
                     entries[hit].ident_low  = r.ident_low;
                  end
                  if (r.hw_addr_present) entries[hit].hw_addr = r.hw_addr;
               end
            end
            OP_QUERY: begin
               for (int i = 0; i < NAT_TABLE_DEPTH && hit < 0; i++)
                  if (entry_used[i] && entries[i].ident_high == r.ident_high &&
                      entries[i].ident_low == r.ident_low) hit = i;
            end
            OP_READ: begin
               if (r.entry_index < NAT_TABLE_DEPTH) begin
                  hit              = int'(r.entry_index);
                  p.out_used       = entry_used[hit];
                  p.out_node_addr  = entries[hit].node_addr;
                  p.out_ident_high = entries[hit].ident_high;
                  p.out_ident_low  = entries[hit].ident_low;
                  p.out_hw_addr    = entries[hit].hw_addr;
               end else begin
                  p.status = ST_RANGE;
               end
            end
            OP_CLEAR: begin
               wipe_table();
               p.status = ST_OK;
            end
            default: begin
            end
         endcase
         if (hit >= 0) begin
            p.status = ST_OK;
            p.slot   = hit[SLOT_W-1:0];
         end
         return p;
      endfunction

      function void note_request(req_payload_type r);
         owed_replies.push_back(predict_reply(r));
      endfunction

      function void check_reply(rsp_payload_type got);
         rsp_payload_type want;
         bit              bad;
         if (owed_replies.size() == 0) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected reply: status=%0d slot=%0d", got.status, got.slot);
            return;
         end
         want = owed_replies.pop_front();
         bad  = (got.status !== want.status) || (got.slot !== want.slot) ||
                (got.out_used !== want.out_used) ||
                (got.out_node_addr !== want.out_node_addr) ||
                (got.out_ident_high !== want.out_ident_high) ||
                (got.out_ident_low !== want.out_ident_low) ||
                (got.out_hw_addr !== want.out_hw_addr);
         if (bad) begin
            errors++;
            mismatches++;
            if (mismatches <= 10) begin
               $display("reply mismatch at %0t", $realtime);
               $display("  expected: st=%0d slot=%0d used=%0b addr=%h id=%h_%h hw=%h",
                        want.status, want.slot, want.out_used, want.out_node_addr,
                        want.out_ident_high, want.out_ident_low, want.out_hw_addr);
               $display("  actual:   st=%0d slot=%0d used=%0b addr=%h id=%h_%h hw=%h",
                        got.status, got.slot, got.out_used, got.out_node_addr,
                        got.out_ident_high, got.out_ident_low, got.out_hw_addr);
            end
         end
      endfunction

      function int owed_count();
         return owed_replies.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   nat_req_if req_ch ();
   nat_rsp_if rsp_ch ();

   node_address_table_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #1 clock = ~clock;

   node_table_scoreboard sb;
   logic [NODE_ADDR_W-1:0]  addr_pool[ADDR_POOL_N];
   logic [IDENT_HALF_W-1:0] ident_pool_hi[IDENT_POOL_N];
   logic [IDENT_HALF_W-1:0] ident_pool_lo[IDENT_POOL_N];
   int   offered;
   int   cycle_count;
   int   hold_count;
   logic hold_off_go;
   logic rsp_steady;

   // Watchdog.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // Response side: random stalls, a steady stretch and one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_off_go && hold_count < HOLD_CYCLES) begin
         rsp_ch.ready <= 1'b0;
         hold_count   <= hold_count + 1;
      end else if (rsp_steady) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= 31);
      end
   end

   // Replies are checked before the request of the same edge is noted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) sb.check_reply(rsp_ch.data);
         if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.data);
      end
   end

   function automatic req_payload_type build_request(
      logic [2:0] op, logic [NODE_ADDR_W-1:0] addr, logic [IDENT_HALF_W-1:0] ih,
      logic [IDENT_HALF_W-1:0] il, logic ip, logic [HW_ADDR_W-1:0] hw, logic hp,
      logic [7:0] idx);
      req_payload_type r;
      r.opcode          = op;
      r.node_addr       = addr;
      r.ident_high      = ih;
      r.ident_low       = il;
      r.ident_present   = ip;
      r.hw_addr         = hw;
      r.hw_addr_present = hp;
      r.entry_index     = idx;
      return r;
   endfunction

   // Content drawn mostly from small pools so that lookups hit often.
   function automatic req_payload_type pooled_request(logic [2:0] op);
      req_payload_type r;
      int              k;
      k = $urandom_range(IDENT_POOL_N - 1);
      r.opcode    = op;
      r.node_addr = ($urandom_range(99) < 75) ? addr_pool[$urandom_range(ADDR_POOL_N - 1)]
                                              : NODE_ADDR_W'($urandom);
      if ($urandom_range(99) < 70) begin
         r.ident_high = ident_pool_hi[k];
         r.ident_low  = ident_pool_lo[k];
      end else begin
         r.ident_high = {$urandom, $urandom};
         r.ident_low  = {$urandom, $urandom};
      end
      r.ident_present   = 1'($urandom_range(1));
      r.hw_addr         = {16'($urandom), 32'($urandom)};
      r.hw_addr_present = 1'($urandom_range(1));
      r.entry_index     = ($urandom_range(99) < 80) ? 8'($urandom_range(NAT_TABLE_DEPTH - 1))
                                                    : 8'($urandom);
      return r;
   endfunction

   function automatic logic [2:0] weighted_opcode();
      int pick;
      pick = $urandom_range(99);
      if (pick < 30) return OP_ADD;
      if (pick < 50) return OP_FIND;
      if (pick < 65) return OP_QUERY;
      if (pick < 86) return OP_READ;
      if (pick < 89) return OP_CLEAR;
      if (pick < 92) return 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
      return OP_FIND;
   endfunction

   // Called at a rising edge; returns at the edge where the transaction is taken.
   task automatic offer_request(input req_payload_type r);
      bit steady;
      steady = (offered >= 700 && offered < 900);
      rsp_steady <= steady;
      while (!steady && $urandom_range(99) < 31) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      offered++;
   endtask

   initial begin
      int              kind;
      int              fill_adds;
      req_payload_type r;
      sb          = new();
      offered     = 0;
      hold_count  = 0;
      reset       <= 1'b1;
      hold_off_go <= 1'b0;
      rsp_steady  <= 1'b0;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      foreach (addr_pool[i]) addr_pool[i] = NODE_ADDR_W'($urandom);
      foreach (ident_pool_hi[i]) begin
         ident_pool_hi[i] = {$urandom, $urandom};
         ident_pool_lo[i] = {$urandom, $urandom};
      end
      ident_pool_hi[0] = '0;
      ident_pool_lo[0] = '0;
      ident_pool_hi[1] = '1;
      ident_pool_lo[1] = '1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty table, edges of every field, update rules, clear.
      offer_request(build_request(OP_READ, '0, '0, '0, 1'b0, '0, 1'b0, 8'd0));
      offer_request(build_request(OP_READ, '0, '0, '0, 1'b0, '0, 1'b0,
                                  8'(NAT_TABLE_DEPTH - 1)));
      offer_request(build_request(OP_READ, '0, '0, '0, 1'b0, '0, 1'b0, 8'(NAT_TABLE_DEPTH)));
      offer_request(build_request(OP_READ, '1, '1, '1, 1'b1, '1, 1'b1, 8'hFF));
      offer_request(build_request(OP_FIND, '0, '0, '0, 1'b0, '0, 1'b0, 8'd0));
      offer_request(build_request(OP_ADD, '0, '1, '1, 1'b1, '1, 1'b1, 8'd0));
      offer_request(build_request(OP_ADD, '1, 64'h0123_4567_89AB_CDEF, '1, 1'b0, '1, 1'b0,
                                  8'd0));
      offer_request(build_request(OP_READ, '0, '0, '0, 1'b0, '0, 1'b0, 8'd1));
      offer_request(build_request(OP_ADD, '1, 64'hA5A5_5A5A_0F0F_F0F0,
                                  64'h1122_3344_5566_7788, 1'b1, '1, 1'b0, 8'd0));
      offer_request(build_request(OP_ADD, '0, '0, '0, 1'b0, '0, 1'b1, 8'd0));
      offer_request(build_request(OP_FIND, '1, '0, '0, 1'b0, '0, 1'b0, 8'd0));
      offer_request(build_request(OP_QUERY, '0, '1, '1, 1'b0, '0, 1'b0, 8'd0));
      offer_request(build_request(OP_QUERY, '0, '0, '0, 1'b0, '0, 1'b0, 8'd0));
      offer_request(build_request(OP_READ, '0, '0, '0, 1'b0, '0, 1'b0, 8'd0));
      offer_request(build_request(OP_READ, '0, '0, '0, 1'b0, '0, 1'b0, 8'd1));
      offer_request(build_request(OP_SPARE_LO, '1, '1, '1, 1'b1, '1, 1'b1, 8'd0));
      offer_request(build_request(OP_SPARE_LO + 3'd1, '0, '0, '0, 1'b0, '0, 1'b0, 8'd1));
      offer_request(build_request(OP_SPARE_HI, '1, '0, '1, 1'b1, '0, 1'b1, 8'hFF));
      offer_request(build_request(OP_CLEAR, '1, '1, '1, 1'b1, '1, 1'b1, 8'hFF));
      offer_request(build_request(OP_READ, '0, '0, '0, 1'b0, '0, 1'b0, 8'd0));
      offer_request(build_request(OP_FIND, '0, '0, '0, 1'b0, '0, 1'b0, 8'd0));
      offer_request(build_request(OP_QUERY, '0, '1, '1, 1'b0, '0, 1'b0, 8'd0));

      // Random part in sequences; the long response hold-off starts early on.
      while (offered < TOTAL_ITEMS) begin
         if (offered >= 100) hold_off_go <= 1'b1;
         kind = $urandom_range(99);
         if (kind < 55) begin
            repeat (30) offer_request(pooled_request(weighted_opcode()));
         end else if (kind < 75) begin
            // Clear, then add until the table overflows, then look around.
            offer_request(pooled_request(OP_CLEAR));
            fill_adds = $urandom_range(38, 34);
            while (fill_adds > 0) begin
               if ($urandom_range(99) < 85) begin
                  r = pooled_request(OP_ADD);
                  if ($urandom_range(99) < 90) r.node_addr = NODE_ADDR_W'($urandom);
                  fill_adds--;
               end else begin
                  r = pooled_request(3'($urandom_range(OP_READ, OP_FIND)));
               end
               offer_request(r);
            end
            repeat (6) offer_request(pooled_request(weighted_opcode()));
         end else begin
            repeat (20) begin
               r = pooled_request(3'($urandom));
               r.node_addr   = NODE_ADDR_W'($urandom);
               r.entry_index = 8'($urandom);
               offer_request(r);
            end
         end
      end
      req_ch.valid <= 1'b0;
      rsp_steady   <= 1'b0;

      while (sb.owed_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.owed_count() != 0) sb.errors++;
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
